[sv/cau_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int DIV_STEPS = 32;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    // One queued item, classified by the front end.
    typedef struct packed {
        action_t            action;
        logic               dz;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } item_t;

    // Handshake between the front queue and the back pipeline.
    typedef struct packed {
        logic  vld;
        item_t item;
    } queue_head_t;

    // Per-item data that travels alongside the divider lanes.
    typedef struct packed {
        action_t     action;
        logic        dz;
        logic        neg_re;
        logic        neg_im;
        logic        big_re;
        logic        big_im;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        ovf;
    } side_t;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } sat_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] lq;
    } div_lane_t;

    // Saturate a sign-magnitude value; big means the magnitude is at least 2^32.
    function automatic sat_t sat_sm(input logic neg, input logic big,
                                    input logic [31:0] mag);
        sat_t r;
        if (!neg) begin
            if (big || mag[31]) begin
                r.ovf = 1'b1;
                r.val = 32'h7FFF_FFFF;
            end else begin
                r.ovf = 1'b0;
                r.val = mag;
            end
        end else begin
            if (big || (mag > 32'h8000_0000)) begin
                r.ovf = 1'b1;
                r.val = 32'h8000_0000;
            end else begin
                r.ovf = 1'b0;
                r.val = 32'(~mag + 32'd1);
            end
        end
        return r;
    endfunction

    // Saturate a 33-bit two's complement sum to 32 bits.
    function automatic sat_t sat_sum(input logic [32:0] s);
        sat_t r;
        if (s[32] != s[31]) begin
            r.ovf = 1'b1;
            r.val = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r.ovf = 1'b0;
            r.val = s[31:0];
        end
        return r;
    endfunction

    // One restoring division step: shift in the next dividend bit, subtract
    // when possible and shift the quotient bit into the low word.
    function automatic div_lane_t div_step(input div_lane_t cur, input logic [63:0] den);
        div_lane_t  r;
        logic [64:0] t;
        logic [64:0] d;
        t = {cur.rem, cur.lq[31]};
        d = {1'b0, den};
        if (t >= d) begin
            r.rem = 64'(t - d);
            r.lq  = {cur.lq[30:0], 1'b1};
        end else begin
            r.rem = t[63:0];
            r.lq  = {cur.lq[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/cau_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Accepts items, flags divides by zero and queues them for the back pipeline.
// ----------------------------------------------------------------------------
module cau_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic signed [31:0] s_a_real,
    input  wire logic signed [31:0] s_a_imag,
    input  wire logic signed [31:0] s_b_real,
    input  wire logic signed [31:0] s_b_imag,
    input  wire logic               pop,
    output cau_pkg::queue_head_t    head
);
    import cau_pkg::*;

    item_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    item_t              in_item;
    logic               push;
    logic               do_pop;

    always_comb begin
        in_item.action = action_t'(s_action);
        in_item.dz     = (action_t'(s_action) == ACT_DIV) &&
                         (s_b_real == 32'sd0) && (s_b_imag == 32'sd0);
        in_item.a_real = s_a_real;
        in_item.a_imag = s_a_imag;
        in_item.b_real = s_b_real;
        in_item.b_imag = s_b_imag;
    end

    assign s_ready   = (count_reg != QCNT_W'(QDEPTH));
    assign push      = s_valid && s_ready;
    assign do_pop    = pop && (count_reg != '0);
    assign head.vld  = (count_reg != '0);
    assign head.item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end else if (do_pop && !push) begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count exceeds depth");
    a_full_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == QCNT_W'(QDEPTH)) |-> !s_ready)
        else $error("ready while queue is full");
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !push) |=> (count_reg == QCNT_W'($past(count_reg) - 1'b1)))
        else $error("queue count did not drop on a pop");
`endif

endmodule
`default_nettype wire

[sv/cau_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_divider
// Two-lane pipelined restoring divider, one quotient bit per stage per lane.
// ----------------------------------------------------------------------------
module cau_divider (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire cau_pkg::side_t       in_side,
    input  wire logic [63:0]          in_den,
    input  wire cau_pkg::div_lane_t   in_re,
    input  wire cau_pkg::div_lane_t   in_im,
    output logic                      out_vld,
    output cau_pkg::side_t            out_side,
    output logic [31:0]               out_q_re,
    output logic [31:0]               out_q_im
);
    import cau_pkg::*;

    logic        vld_reg  [DIV_STEPS];
    side_t       side_reg [DIV_STEPS];
    logic [63:0] den_reg  [DIV_STEPS];
    div_lane_t   re_reg   [DIV_STEPS];
    div_lane_t   im_reg   [DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STEPS; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i < DIV_STEPS; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            den_reg[0]  <= in_den;
            re_reg[0]   <= div_step(in_re, in_den);
            im_reg[0]   <= div_step(in_im, in_den);
            for (int i = 1; i < DIV_STEPS; i++) begin
                side_reg[i] <= side_reg[i-1];
                den_reg[i]  <= den_reg[i-1];
                re_reg[i]   <= div_step(re_reg[i-1], den_reg[i-1]);
                im_reg[i]   <= div_step(im_reg[i-1], den_reg[i-1]);
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STEPS-1];
    assign out_side = side_reg[DIV_STEPS-1];
    assign out_q_re = re_reg[DIV_STEPS-1].lq;
    assign out_q_im = im_reg[DIV_STEPS-1].lq;

endmodule
`default_nettype wire

[sv/cau_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, magnitudes, division and saturation.
// ----------------------------------------------------------------------------
module cau_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cau_pkg::queue_head_t head,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [31:0]        m_res_real,
    output logic signed [31:0]        m_res_imag,
    output logic                      m_overflow,
    output logic                      m_div_zero
);
    import cau_pkg::*;

    logic en;

    // Stage 1: products and add/subtract results.
    logic               s1_vld_reg;
    side_t              s1_side_reg, s1_side_next;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, q_rr_reg, q_ii_reg;
    // Stage 2: wide sums and the divisor's squared magnitude.
    logic               s2_vld_reg;
    side_t              s2_side_reg;
    logic signed [64:0] sum_re_reg, sum_im_reg, sum_re_next, sum_im_next;
    logic [63:0]        den2_reg;
    // Stage 3: sign and magnitude.
    logic               s3_vld_reg;
    side_t              s3_side_reg;
    logic [63:0]        mag_re_reg, mag_im_reg, den3_reg;
    logic               neg_re_reg, neg_im_reg;
    // Stage 4: multiply results and the quotient range check.
    logic               s4_vld_reg;
    side_t              s4_side_reg, s4_side_next;
    logic [63:0]        mag4_re_reg, mag4_im_reg, den4_reg;
    // Divider and output register.
    div_lane_t          lane_re, lane_im;
    logic               dv_vld;
    side_t              dv_side;
    logic [31:0]        dv_q_re, dv_q_im;
    logic               out_vld_reg;
    logic [31:0]        out_re_reg, out_im_reg, out_re_next, out_im_next;
    logic               out_ovf_reg, out_dz_reg, out_ovf_next, out_dz_next;
    sat_t               sat_a, sat_b;

    // The whole pipeline moves together whenever the output slot is empty or its result is taken.
    assign en  = !out_vld_reg || m_ready;
    assign pop = en;

    always_comb begin
        sat_a = sat_sum(33'({head.item.a_real[31], head.item.a_real}
                        + (head.item.action == ACT_SUB
                           ? -{head.item.b_real[31], head.item.b_real}
                           : {head.item.b_real[31], head.item.b_real})));
        sat_b = sat_sum(33'({head.item.a_imag[31], head.item.a_imag}
                        + (head.item.action == ACT_SUB
                           ? -{head.item.b_imag[31], head.item.b_imag}
                           : {head.item.b_imag[31], head.item.b_imag})));
        s1_side_next        = '0;
        s1_side_next.action = head.item.action;
        s1_side_next.dz     = head.item.dz;
        s1_side_next.res_re = sat_a.val;
        s1_side_next.res_im = sat_b.val;
        s1_side_next.ovf    = sat_a.ovf || sat_b.ovf;
    end

    always_comb begin
        if (s1_side_reg.action == ACT_MUL) begin
            sum_re_next = {p_rr_reg[63], p_rr_reg} - {p_ii_reg[63], p_ii_reg};
            sum_im_next = {p_ri_reg[63], p_ri_reg} + {p_ir_reg[63], p_ir_reg};
        end else begin
            sum_re_next = {p_rr_reg[63], p_rr_reg} + {p_ii_reg[63], p_ii_reg};
            sum_im_next = {p_ir_reg[63], p_ir_reg} - {p_ri_reg[63], p_ri_reg};
        end
    end

    always_comb begin
        sat_t m_re;
        sat_t m_im;
        m_re = sat_sm(neg_re_reg, |mag_re_reg[63:48], mag_re_reg[47:16]);
        m_im = sat_sm(neg_im_reg, |mag_im_reg[63:48], mag_im_reg[47:16]);
        s4_side_next        = s3_side_reg;
        s4_side_next.neg_re = neg_re_reg;
        s4_side_next.neg_im = neg_im_reg;
        // The quotient reaches 2^32 exactly when mag >= den * 2^16.
        s4_side_next.big_re = ({16'd0, mag_re_reg} >= {den3_reg, 16'd0});
        s4_side_next.big_im = ({16'd0, mag_im_reg} >= {den3_reg, 16'd0});
        if (s3_side_reg.action == ACT_MUL) begin
            s4_side_next.res_re = m_re.val;
            s4_side_next.res_im = m_im.val;
            s4_side_next.ovf    = m_re.ovf || m_im.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg  <= head.vld;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= s1_side_next;
            p_rr_reg    <= head.item.a_real * head.item.b_real;
            p_ii_reg    <= head.item.a_imag * head.item.b_imag;
            p_ri_reg    <= head.item.a_real * head.item.b_imag;
            p_ir_reg    <= head.item.a_imag * head.item.b_real;
            q_rr_reg    <= head.item.b_real * head.item.b_real;
            q_ii_reg    <= head.item.b_imag * head.item.b_imag;

            s2_side_reg <= s1_side_reg;
            sum_re_reg  <= sum_re_next;
            sum_im_reg  <= sum_im_next;
            den2_reg    <= 64'(q_rr_reg) + 64'(q_ii_reg);

            s3_side_reg <= s2_side_reg;
            neg_re_reg  <= sum_re_reg[64];
            neg_im_reg  <= sum_im_reg[64];
            mag_re_reg  <= sum_re_reg[64] ? 64'(-sum_re_reg) : sum_re_reg[63:0];
            mag_im_reg  <= sum_im_reg[64] ? 64'(-sum_im_reg) : sum_im_reg[63:0];
            den3_reg    <= den2_reg;

            s4_side_reg <= s4_side_next;
            mag4_re_reg <= mag_re_reg;
            mag4_im_reg <= mag_im_reg;
            den4_reg    <= den3_reg;

            out_re_reg  <= out_re_next;
            out_im_reg  <= out_im_next;
            out_ovf_reg <= out_ovf_next;
            out_dz_reg  <= out_dz_next;
        end
    end

    // The dividend is mag * 2^16; its top 48 bits seed the remainder.
    assign lane_re.rem = {16'd0, mag4_re_reg[63:16]};
    assign lane_re.lq  = {mag4_re_reg[15:0], 16'd0};
    assign lane_im.rem = {16'd0, mag4_im_reg[63:16]};
    assign lane_im.lq  = {mag4_im_reg[15:0], 16'd0};

    cau_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s4_vld_reg),
        .in_side  (s4_side_reg),
        .in_den   (den4_reg),
        .in_re    (lane_re),
        .in_im    (lane_im),
        .out_vld  (dv_vld),
        .out_side (dv_side),
        .out_q_re (dv_q_re),
        .out_q_im (dv_q_im)
    );

    always_comb begin
        sat_t d_re;
        sat_t d_im;
        d_re = sat_sm(dv_side.neg_re, dv_side.big_re, dv_q_re);
        d_im = sat_sm(dv_side.neg_im, dv_side.big_im, dv_q_im);
        out_re_next  = dv_side.res_re;
        out_im_next  = dv_side.res_im;
        out_ovf_next = dv_side.ovf;
        out_dz_next  = 1'b0;
        if (dv_side.action == ACT_DIV) begin
            if (dv_side.dz) begin
                out_re_next  = '0;
                out_im_next  = '0;
                out_ovf_next = 1'b0;
                out_dz_next  = 1'b1;
            end else begin
                out_re_next  = d_re.val;
                out_im_next  = d_im.val;
                out_ovf_next = d_re.ovf || d_im.ovf;
            end
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_res_real = out_re_reg;
    assign m_res_imag = out_im_reg;
    assign m_overflow = out_ovf_reg;
    assign m_div_zero = out_dz_reg;

`ifndef NO_ASSERTIONS
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |=> (out_vld_reg && $stable(out_re_reg)))
        else $error("result changed while stalled");
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_dz_reg) |-> (out_re_reg == '0 && out_im_reg == '0))
        else $error("divide by zero gave nonzero parts");
    a_dz_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> !(out_dz_reg && out_ovf_reg))
        else $error("overflow raised together with divide by zero");
`endif

endmodule
`default_nettype wire

[sv/complex_arith_unit_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// Complex add, subtract, multiply and divide on signed Q16.16 operands.
// ----------------------------------------------------------------------------
// The unit takes one transfer per cycle while the input queue has room and
// returns one result per transfer, in order. The transfer writes the
// four-entry input queue, then the item passes four stages of products, sums,
// magnitudes and the quotient range check, 32 stages of the two-lane
// restoring divider (one quotient bit per stage) and one output register.
// Every operation runs through the same pipeline; a stalled result holds the
// whole pipeline while the input queue fills.
// Results that leave the Q16.16 range saturate and set overflow; a divide by
// zero returns zero parts and div_zero.
module complex_arith_unit_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic signed [31:0] s_a_real,
    input  wire logic signed [31:0] s_a_imag,
    input  wire logic signed [31:0] s_b_real,
    input  wire logic signed [31:0] s_b_imag,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_res_real,
    output logic signed [31:0]      m_res_imag,
    output logic                    m_overflow,
    output logic                    m_div_zero
);
    import cau_pkg::*;

    queue_head_t head;
    logic        pop;

    cau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_a_real (s_a_real),
        .s_a_imag (s_a_imag),
        .s_b_real (s_b_real),
        .s_b_imag (s_b_imag),
        .pop      (pop),
        .head     (head)
    );

    cau_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res_real (m_res_real),
        .m_res_imag (m_res_imag),
        .m_overflow (m_overflow),
        .m_div_zero (m_div_zero)
    );

endmodule
`default_nettype wire

[sim/complex_arith_unit_top_test.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit_top_test
// Self-checking bench for the complex arithmetic unit: directed edge cases,
// then random operands under several sender and receiver idling patterns.
// Each transfer's expected result is predicted at full width and compared
// in order with the results that come out.
// ----------------------------------------------------------------------------
module complex_arith_unit_top_test;
    import cau_pkg::*;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        ovf;
        logic        dz;
    } cplx_res_t;

    class cplx_scoreboard;
        cplx_res_t pending_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_input(input cplx_res_t e);
            pending_q.push_back(e);
        endfunction

        task check_result(input cplx_res_t got);
            cplx_res_t e;
            if (pending_q.size() == 0) begin
                report("result with no transfer outstanding");
            end else begin
                e = pending_q.pop_front();
                if (got.re !== e.re)
                    report($sformatf("res_real %h, expected %h", got.re, e.re));
                if (got.im !== e.im)
                    report($sformatf("res_imag %h, expected %h", got.im, e.im));
                if (got.ovf !== e.ovf)
                    report($sformatf("overflow %b, expected %b", got.ovf, e.ovf));
                if (got.dz !== e.dz)
                    report($sformatf("div_zero %b, expected %b", got.dz, e.dz));
            end
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_action;
    logic signed [31:0] s_a_real;
    logic signed [31:0] s_a_imag;
    logic signed [31:0] s_b_real;
    logic signed [31:0] s_b_imag;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_res_real;
    logic signed [31:0] m_res_imag;
    logic               m_overflow;
    logic               m_div_zero;

    cplx_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req_cnt;
    int hold_seen_cnt;
    int hold_left;

    complex_arith_unit_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_a_real  (s_a_real),
        .s_a_imag  (s_a_imag),
        .s_b_real  (s_b_real),
        .s_b_imag  (s_b_imag),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res_real(m_res_real),
        .m_res_imag(m_res_imag),
        .m_overflow(m_overflow),
        .m_div_zero(m_div_zero)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Clamp a sign-magnitude value into Q16.16.
    function automatic logic [31:0] clamp_q16(input logic neg, input logic [127:0] mag,
                                              inout logic ovf);
        if (!neg) begin
            if (mag > 128'h7FFF_FFFF) begin
                ovf = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return mag[31:0];
        end
        if (mag > 128'h8000_0000) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return ~mag[31:0] + 32'd1;
    endfunction

    function automatic logic [127:0] abs128(input logic signed [127:0] v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic cplx_res_t predict_cplx(input action_t act,
                                               input logic signed [31:0] a_re,
                                               input logic signed [31:0] a_im,
                                               input logic signed [31:0] b_re,
                                               input logic signed [31:0] b_im);
        cplx_res_t r;
        logic signed [127:0] ar, ai, br, bi, sre, sim;
        logic [127:0] den;
        ar = a_re;
        ai = a_im;
        br = b_re;
        bi = b_im;
        r.ovf = 1'b0;
        r.dz  = 1'b0;
        r.re  = '0;
        r.im  = '0;
        case (act)
            ACT_ADD: begin
                sre = ar + br;
                sim = ai + bi;
                r.re = clamp_q16(sre < 0, abs128(sre), r.ovf);
                r.im = clamp_q16(sim < 0, abs128(sim), r.ovf);
            end
            ACT_SUB: begin
                sre = ar - br;
                sim = ai - bi;
                r.re = clamp_q16(sre < 0, abs128(sre), r.ovf);
                r.im = clamp_q16(sim < 0, abs128(sim), r.ovf);
            end
            ACT_MUL: begin
                sre = ar * br - ai * bi;
                sim = ar * bi + ai * br;
                r.re = clamp_q16(sre < 0, abs128(sre) >> 16, r.ovf);
                r.im = clamp_q16(sim < 0, abs128(sim) >> 16, r.ovf);
            end
            default: begin
                den = 128'(br * br + bi * bi);
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    // Truncated quotient of the conjugate product over |B|^2.
                    sre = ar * br + ai * bi;
                    sim = ai * br - ar * bi;
                    r.re = clamp_q16(sre < 0, (abs128(sre) << 16) / den, r.ovf);
                    r.im = clamp_q16(sim < 0, (abs128(sim) << 16) / den, r.ovf);
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'd0;
            3: v = 32'h0001_0000;
            4, 5: begin
                v = $urandom_range(0, 32'h0004_0000);
                if ($urandom_range(0, 1) == 1)
                    v = ~v + 32'd1;
            end
            6: begin
                v = $urandom_range(0, 32'h0100_0000);
                if ($urandom_range(0, 1) == 1)
                    v = ~v + 32'd1;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task send_item(input action_t act, input logic [31:0] ar, input logic [31:0] ai,
                   input logic [31:0] br, input logic [31:0] bi);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_action <= act;
        s_a_real <= ar;
        s_a_imag <= ai;
        s_b_real <= br;
        s_b_imag <= bi;
        s_valid  <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_input(predict_cplx(act, ar, ai, br, bi));
    endtask

    task send_random(input int n);
        action_t act;
        logic [31:0] br, bi;
        repeat (n) begin
            act = action_t'($urandom_range(0, 3));
            br  = pick_operand();
            bi  = pick_operand();
            if (act == ACT_DIV && $urandom_range(0, 15) == 0) begin
                br = '0;
                bi = '0;
            end
            send_item(act, pick_operand(), pick_operand(), br, bi);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_res_real, m_res_imag, m_overflow, m_div_zero});
        if (hold_req_cnt != hold_seen_cnt) begin
            hold_seen_cnt <= hold_req_cnt;
            hold_left     <= 300;
            m_ready       <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_action      = ACT_ADD;
        s_a_real      = '0;
        s_a_imag      = '0;
        s_b_real      = '0;
        s_b_imag      = '0;
        m_ready       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_cnt  = 0;
        hold_seen_cnt = 0;
        hold_left     = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, saturation in both directions, zero divisor.
        send_item(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(ACT_SUB, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
        send_item(ACT_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
        send_item(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(ACT_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(ACT_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(ACT_MUL, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_item(ACT_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(ACT_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_item(ACT_DIV, 32'h0006_0000, 32'h0004_0000, 32'h0001_0000, 32'h0001_0000);
        send_item(ACT_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000);
        send_item(ACT_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001);
        send_item(ACT_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_item(ACT_DIV, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(ACT_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0003_0000, 32'hFFFC_0000);
        send_item(ACT_DIV, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
        send_item(ACT_DIV, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000);

        send_random(150);
        send_idle_pct = 45;
        send_random(130);
        send_idle_pct = 0;
        recv_idle_pct = 45;
        send_random(130);
        send_idle_pct = 32;
        recv_idle_pct = 32;
        send_random(130);
        // The receiver holds off while items keep coming, so the input stalls.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_cnt  = hold_req_cnt + 1;
        send_random(110);

        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
